>>> hw/rtl/lpm4n_pkg.sv
// Shared constants and transaction types for the 4-neighbor local peak marker.
`default_nettype none

package lpm4n_pkg;

   // Geometry
   localparam int MAX_COLS    = 1024;
   localparam int PIXEL_WIDTH = 16;
   localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W       = COL_W + 1;
   localparam int ADDR_W      = COL_W + 1;
   localparam int ROW_W       = 16;

   // Register file
   localparam int ROWS_CFG_W = 16;
   localparam int COLS_CFG_W = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int COLS_CMP_W = (COLS_CFG_W > CNT_W) ? COLS_CFG_W : CNT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 1'b1;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 16'd480;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd640;

   // Input actions
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   // Queue sizes
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;

   // Work item passed from front to back
   typedef struct packed {
      logic                          emit;
      logic                          write;
      logic                          has_up;
      logic                          has_right;
      logic                          has_down;
      logic                          last;
      logic [ROW_W-1:0]              row;
      logic [COL_W-1:0]              col;
      logic                          wr_par;
      logic [COL_W-1:0]              wr_col;
      logic signed [PIXEL_WIDTH-1:0] data;
   } cmd_type;

   // Result transaction
   typedef struct packed {
      logic             is_peak;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/lpm4n_front.sv
// Front end: register file, raster counters and command generation.
`default_nettype none

module lpm4n_front
   import lpm4n_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic                          req_action,
   input  wire logic signed [PIXEL_WIDTH-1:0] req_pixel,
   input  wire logic                          csr_write,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data,
   input  wire logic                          cmd_full,
   output cmd_type                            cmd_data,
   output logic                               cmd_push
);

   logic [ROWS_CFG_W-1:0] rows_ff, rows_in;
   logic [COLS_CFG_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0]      in_col_ff, in_col_in;
   logic [ROW_W-1:0]      out_row_ff, out_row_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic                  full_ff, full_in;

   logic [COLS_CMP_W-1:0] cols_wide;
   logic [CNT_W-1:0]      eff_cols;
   logic [ROW_W-1:0]      eff_rows;
   logic [COL_W-1:0]      ic, oc;
   logic                  ic_last, oc_last, dc_last, row_last;
   logic                  accept;

   assign accept = req_push && !cmd_full;

   // Clamp the configured geometry
   assign cols_wide = COLS_CMP_W'(cols_ff);
   always_comb begin
      if (cols_ff == '0) begin
         eff_cols = CNT_W'(1);
      end else if (cols_wide > COLS_CMP_W'(MAX_COLS)) begin
         eff_cols = CNT_W'(MAX_COLS);
      end else begin
         eff_cols = CNT_W'(cols_wide);
      end
   end
   assign eff_rows = (rows_ff == '0) ? ROW_W'(1) : ROW_W'(rows_ff);

   // Wrap column counters that passed a smaller width
   assign ic       = ({1'b0, in_col_ff} >= eff_cols) ? '0 : in_col_ff;
   assign oc       = ({1'b0, out_col_ff} >= eff_cols) ? '0 : out_col_ff;
   assign ic_last  = ({1'b0, ic} + CNT_W'(1)) >= eff_cols;
   assign oc_last  = ({1'b0, oc} + CNT_W'(1)) >= eff_cols;
   assign dc_last  = ({1'b0, out_col_ff} + CNT_W'(1)) >= eff_cols;
   assign row_last = ({1'b0, in_row_ff} + (ROW_W+1)'(1)) >= {1'b0, eff_rows};

   // Classify the transaction and advance the counters
   always_comb begin
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      full_in    = full_ff;
      cmd_push   = 1'b0;
      cmd_data   = '0;

      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_ROWS: rows_in = csr_data[ROWS_CFG_W-1:0];
            CSR_FRAME_COLS: cols_in = csr_data[COLS_CFG_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (req_action == ACT_DRAIN) begin
            // Flush one flag of the last row
            if (full_ff) begin
               cmd_push           = 1'b1;
               cmd_data.emit      = 1'b1;
               cmd_data.row       = out_row_ff;
               cmd_data.col       = out_col_ff;
               cmd_data.has_up    = (out_row_ff != '0);
               cmd_data.has_right = !dc_last;
               cmd_data.last      = dc_last;
               if (dc_last) begin
                  in_row_in  = '0;
                  in_col_in  = '0;
                  out_row_in = '0;
                  out_col_in = '0;
                  full_in    = 1'b0;
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end else if (!full_ff) begin
            // Store the pixel, flag the one above it
            cmd_push        = 1'b1;
            cmd_data.write  = 1'b1;
            cmd_data.wr_par = in_row_ff[0];
            cmd_data.wr_col = ic;
            cmd_data.data   = req_pixel;
            if (in_row_ff != '0) begin
               cmd_data.emit      = 1'b1;
               cmd_data.row       = out_row_ff;
               cmd_data.col       = oc;
               cmd_data.has_up    = (out_row_ff != '0);
               cmd_data.has_right = !oc_last;
               cmd_data.has_down  = 1'b1;
               if (oc_last) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = oc + COL_W'(1);
               end
            end
            if (ic_last) begin
               in_col_in = '0;
               if (row_last) begin
                  full_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_in = ic + COL_W'(1);
            end
         end
      end
   end

   // Hold registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RESET;
         cols_ff    <= COLS_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         full_ff    <= 1'b0;
      end else begin
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         full_ff    <= full_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lpm4n_cmd_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module lpm4n_cmd_queue
   import lpm4n_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type                entries_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CMD_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CMD_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lpm4n_back.sv
// Back end: two-row line store, neighbor window, peak compare and result queue.
`default_nettype none

module lpm4n_back
   import lpm4n_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_empty,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_is_peak,
   output logic [ROW_W-1:0] rsp_row_index,
   output logic [COL_W-1:0] rsp_col_index,
   output logic             rsp_frame_last
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_FIRST,
      D_FINAL
   } dkind_type;

   // Line store: row parity in the top address bit
   logic signed [PIXEL_WIDTH-1:0] line_mem [2**ADDR_W];
   logic signed [PIXEL_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]             addr_a, addr_b, addr_w;
   logic                          mem_we;

   // Issue control
   logic      split, fresh, is_first, rsp_space;
   logic      issue_write_only, issue_first, issue_final;
   logic      split_done_ff, split_done_in;

   // Data stage
   dkind_type d_kind_ff, d_kind_in;
   cmd_type   d_cmd_ff;
   logic      d_split_ff;
   logic      d_fresh;
   logic signed [PIXEL_WIDTH-1:0] win_center_ff, win_center_in;
   logic signed [PIXEL_WIDTH-1:0] win_right_ff, win_right_in;
   logic signed [PIXEL_WIDTH-1:0] hold_center_ff, hold_up_ff;
   logic signed [PIXEL_WIDTH-1:0] center, up, right, left;
   logic      peak;
   rsp_type   d_rsp;

   // Result queue
   rsp_type              rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rsp_wr_ptr_ff, rsp_wr_ptr_in;
   logic [RSP_PTR_W-1:0] rsp_rd_ptr_ff, rsp_rd_ptr_in;
   logic [RSP_PTR_W:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_push, rsp_take;
   rsp_type              rsp_head;

   // Decide what the head command does this cycle
   assign fresh     = (cmd_data.col == '0);
   assign split     = cmd_data.emit && fresh && cmd_data.has_right;
   assign is_first  = split && !split_done_ff;
   assign rsp_space = ({1'b0, rsp_count_ff} + (RSP_PTR_W+2)'(d_kind_ff == D_FINAL))
                      < (RSP_PTR_W+2)'(RSP_DEPTH);

   assign issue_write_only = !cmd_empty && !cmd_data.emit;
   assign issue_first      = !cmd_empty && is_first;
   assign issue_final      = !cmd_empty && cmd_data.emit && !is_first && rsp_space;
   assign cmd_pop          = issue_write_only || issue_final;

   // Port A: center on a row start, else right; port B: upper neighbor
   assign addr_a = (fresh && !split_done_ff) ? {cmd_data.row[0], cmd_data.col}
                                             : {cmd_data.row[0], cmd_data.col + COL_W'(1)};
   assign addr_b = {~cmd_data.row[0], cmd_data.col};
   assign addr_w = {cmd_data.wr_par, cmd_data.wr_col};
   assign mem_we = cmd_pop && cmd_data.write;

   always_comb begin
      split_done_in = split_done_ff;
      if (issue_first) begin
         split_done_in = 1'b1;
      end else if (issue_final) begin
         split_done_in = 1'b0;
      end
      if (issue_first) begin
         d_kind_in = D_FIRST;
      end else if (issue_final) begin
         d_kind_in = D_FINAL;
      end else begin
         d_kind_in = D_IDLE;
      end
   end

   // Read before write on the same address returns the old entry
   always_ff @(posedge clock) begin
      rd_a_ff <= line_mem[addr_a];
      rd_b_ff <= line_mem[addr_b];
      if (mem_we) begin
         line_mem[addr_w] <= cmd_data.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_done_ff <= 1'b0;
         d_kind_ff     <= D_IDLE;
      end else begin
         split_done_ff <= split_done_in;
         d_kind_ff     <= d_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      d_cmd_ff   <= cmd_data;
      d_split_ff <= split;
   end

   // Assemble the neighborhood and compare
   assign d_fresh = (d_cmd_ff.col == '0);
   assign center  = !d_fresh ? win_right_ff : (d_split_ff ? hold_center_ff : rd_a_ff);
   assign right   = rd_a_ff;
   assign up      = d_split_ff ? hold_up_ff : rd_b_ff;
   assign left    = win_center_ff;

   assign peak = !(d_cmd_ff.has_up && (center <= up))
              && !(d_cmd_ff.has_down && (center <= d_cmd_ff.data))
              && !(!d_fresh && (center <= left))
              && !(d_cmd_ff.has_right && (center <= right));

   always_comb begin
      d_rsp.is_peak = peak;
      d_rsp.row     = d_cmd_ff.row;
      d_rsp.col     = d_cmd_ff.col;
      d_rsp.last    = d_cmd_ff.last;
      win_center_in = win_center_ff;
      win_right_in  = win_right_ff;
      if (d_kind_ff == D_FINAL) begin
         win_center_in = center;
         win_right_in  = right;
      end
   end

   // Slide the window; hold row-start reads across the two phases
   always_ff @(posedge clock) begin
      win_center_ff <= win_center_in;
      win_right_ff  <= win_right_in;
      if (d_kind_ff == D_FIRST) begin
         hold_center_ff <= rd_a_ff;
         hold_up_ff     <= rd_b_ff;
      end
   end

   // Result queue
   assign rsp_push  = (d_kind_ff == D_FINAL);
   assign rsp_empty = (rsp_count_ff == '0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_head  = rsp_mem_ff[rsp_rd_ptr_ff];

   assign rsp_is_peak    = rsp_head.is_peak;
   assign rsp_row_index  = rsp_head.row;
   assign rsp_col_index  = rsp_head.col;
   assign rsp_frame_last = rsp_head.last;

   always_comb begin
      rsp_wr_ptr_in = rsp_push ? rsp_wr_ptr_ff + RSP_PTR_W'(1) : rsp_wr_ptr_ff;
      rsp_rd_ptr_in = rsp_take ? rsp_rd_ptr_ff + RSP_PTR_W'(1) : rsp_rd_ptr_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_push && !rsp_take) begin
         rsp_count_in = rsp_count_ff + (RSP_PTR_W+1)'(1);
      end else if (rsp_take && !rsp_push) begin
         rsp_count_in = rsp_count_ff - (RSP_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_count_ff  <= '0;
      end else begin
         rsp_wr_ptr_ff <= rsp_wr_ptr_in;
         rsp_rd_ptr_ff <= rsp_rd_ptr_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_mem_ff[rsp_wr_ptr_ff] <= d_rsp;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/local_peak_marker_4n.sv
// Top level of the 4-neighbor local peak marker for raster pixel streams.
//
// Pixels enter in raster order, one per clock while req_full is low. The flag
// for a pixel comes out once the pixel below it has entered; drain items flush
// the last row, one flag each. A front end classifies each transaction and
// advances the frame counters in the cycle it is accepted, then hands a
// command through a four-entry queue to the back end, which reads the two-row
// line store (one write and two read ports), compares the neighbors and puts
// the flag into a four-entry result queue. The back end finishes one command
// per clock while the result queue has room, except the first flag of each
// row in frames wider than one column, which is issued in two phases for its
// third store read. A flag passes through the command queue, the store read
// registers and the result queue on its way to the result ports. The line
// store needs no clearing after reset: entries are read only once written.
// frame_rows and frame_cols are written through the csr_ port at indexes 0 and 1
// by the user, who must do so only while the block is idle; it is not enforced.
`default_nettype none

module local_peak_marker_4n
   import lpm4n_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_action,
   input  wire logic signed [PIXEL_WIDTH-1:0] req_pixel,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic                               rsp_is_peak,
   output logic [ROW_W-1:0]                   rsp_row_index,
   output logic [COL_W-1:0]                   rsp_col_index,
   output logic                               rsp_frame_last,
   input  wire logic                          csr_write,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data
);

   cmd_type cmd_in_data, cmd_out_data;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;

   assign req_full = cmd_full;

   // Classify transactions and track the raster position
   lpm4n_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_action (req_action),
      .req_pixel  (req_pixel),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_full   (cmd_full),
      .cmd_data   (cmd_in_data),
      .cmd_push   (cmd_push)
   );

   // Decouple the front end from the back end
   lpm4n_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // Store pixels, compare neighbors, queue flags
   lpm4n_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd_data       (cmd_out_data),
      .cmd_pop        (cmd_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_is_peak    (rsp_is_peak),
      .rsp_row_index  (rsp_row_index),
      .rsp_col_index  (rsp_col_index),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the 4-neighbor local peak marker.
`timescale 1ns / 100ps

module tb_top
   import lpm4n_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned GAP_TOP      = 18;
   localparam int unsigned RANDOM_ITEMS = 150;
   localparam int unsigned SETTLE_WAIT  = 12;
   localparam int unsigned OPEN_EXTRA   = 32;

   localparam logic signed [PIXEL_WIDTH-1:0] PIX_MAX = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
   localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

   typedef struct {
      logic                          action;
      logic signed [PIXEL_WIDTH-1:0] pixel;
      int unsigned                   gap;
      bit                            settle;
   } stream_item_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_push       = 1'b0;
   logic                          req_full;
   logic                          req_action     = ACT_PIXEL;
   logic signed [PIXEL_WIDTH-1:0] req_pixel      = '0;
   logic                          rsp_empty;
   logic                          rsp_pop        = 1'b0;
   logic                          rsp_is_peak;
   logic [ROW_W-1:0]              rsp_row_index;
   logic [COL_W-1:0]              rsp_col_index;
   logic                          rsp_frame_last;
   logic                          csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index      = CSR_FRAME_ROWS;
   logic [CSR_DATA_W-1:0]         csr_data       = '0;

   // Pixel stream waiting to be sent and peak flags waiting to come back
   stream_item_type stream_q[$];
   rsp_type         peak_flags_q[$];

   stream_item_type cur_item;
   bit           holding      = 1'b0;
   int unsigned  gap_left     = 0;
   int unsigned  stall_left   = 0;
   int unsigned  rsp_stall_top = GAP_TOP;
   int unsigned  mismatches   = 0;
   int unsigned  cycles       = 0;
   int unsigned  random_items = 0;

   // Shadow of the marker: frame registers, two-row line store and counters
   logic [ROWS_CFG_W-1:0]         rows_reg = ROWS_RESET;
   logic [COLS_CFG_W-1:0]         cols_reg = COLS_RESET;
   logic signed [PIXEL_WIDTH-1:0] line_copy [2*MAX_COLS];
   int unsigned                   in_r = 0, in_c = 0, out_r = 0, out_c = 0;
   bit                            frame_done = 1'b0;

   local_peak_marker_4n dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_pixel      (req_pixel),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_is_peak    (rsp_is_peak),
      .rsp_row_index  (rsp_row_index),
      .rsp_col_index  (rsp_col_index),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int unsigned eff_rows();
      return (rows_reg == 0) ? 1 : int'(rows_reg);
   endfunction

   function automatic int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return int'(cols_reg);
   endfunction

   function automatic int unsigned slot_of(int unsigned r, int unsigned c);
      return ((r & 1) * MAX_COLS + c) % (2 * MAX_COLS);
   endfunction

   // Flag for the pixel at (out_r, out_c); the lower neighbor is given when it exists
   function automatic rsp_type flag_at(bit has_down, logic signed [PIXEL_WIDTH-1:0] down,
                                       bit last);
      rsp_type                       f;
      logic signed [PIXEL_WIDTH-1:0] c;
      int unsigned                   cols;
      cols = eff_cols();
      c = line_copy[slot_of(out_r, out_c)];
      f.is_peak = 1'b1;
      if (out_r > 0 && c <= line_copy[slot_of(out_r - 1, out_c)]) f.is_peak = 1'b0;
      if (has_down && c <= down) f.is_peak = 1'b0;
      if (out_c > 0 && c <= line_copy[slot_of(out_r, out_c - 1)]) f.is_peak = 1'b0;
      if (out_c + 1 < cols && c <= line_copy[slot_of(out_r, out_c + 1)]) f.is_peak = 1'b0;
      f.row  = ROW_W'(out_r);
      f.col  = COL_W'(out_c);
      f.last = last;
      return f;
   endfunction

   // Advance the shadow by one accepted transaction and queue the flag it yields
   task automatic advance_marker(logic action, logic signed [PIXEL_WIDTH-1:0] pixel);
      int unsigned rows;
      int unsigned cols;
      rsp_type     f;
      rows = eff_rows();
      cols = eff_cols();
      if (action == ACT_DRAIN) begin
         if (!frame_done) return;
         f = flag_at(1'b0, '0, out_c + 1 >= cols);
         peak_flags_q.push_back(f);
         if (f.last) begin
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
            frame_done = 1'b0;
         end else begin
            out_c++;
         end
      end else begin
         if (frame_done) return;
         if (in_c >= cols) in_c = 0;
         if (in_r > 0) begin
            if (out_c >= cols) out_c = 0;
            peak_flags_q.push_back(flag_at(1'b1, pixel, 1'b0));
            if (out_c + 1 >= cols) begin
               out_c = 0;
               out_r = (out_r + 1) & 32'hFFFF;
            end else begin
               out_c++;
            end
         end
         line_copy[slot_of(in_r, in_c)] = pixel;
         if (in_c + 1 >= cols) begin
            in_c = 0;
            if (in_r + 1 >= rows) frame_done = 1'b1;
            else in_r = (in_r + 1) & 32'hFFFF;
         end else begin
            in_c++;
         end
      end
   endtask

   function automatic int unsigned draw_gap(int unsigned top);
      if (top == 0 || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, top);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Driver: feed the stream, predict each accepted transaction
   always @(posedge clock) begin
      logic push_nxt;
      push_nxt = req_push;
      if (reset) begin
         push_nxt = 1'b0;
      end else begin
         if (req_push && !req_full) begin
            advance_marker(req_action, req_pixel);
            holding  = 1'b0;
            push_nxt = 1'b0;
         end
         if (!holding && stream_q.size() > 0) begin
            cur_item = stream_q.pop_front();
            holding  = 1'b1;
            gap_left = cur_item.gap;
         end
         // Hold off for the drawn gap, or until all flags are back on a settle item
         if (holding && !push_nxt) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!cur_item.settle || peak_flags_q.size() == 0) begin
               push_nxt = 1'b1;
               req_action <= cur_item.action;
               req_pixel  <= cur_item.pixel;
            end
         end
      end
      req_push <= push_nxt;
   end

   // Monitor: check each popped flag against the oldest prediction
   always @(posedge clock) begin
      logic    pop_nxt;
      rsp_type want;
      pop_nxt = rsp_pop;
      if (reset) begin
         pop_nxt = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (peak_flags_q.size() == 0) begin
               $error("unexpected transaction row %0d col %0d", rsp_row_index, rsp_col_index);
               mismatches++;
            end else begin
               want = peak_flags_q.pop_front();
               check_field("is_peak", want.is_peak, rsp_is_peak);
               check_field("row_index", want.row, rsp_row_index);
               check_field("col_index", want.col, rsp_col_index);
               check_field("frame_last", want.last, rsp_frame_last);
            end
            stall_left = draw_gap(rsp_stall_top);
            pop_nxt = (stall_left == 0);
         end else if (!rsp_pop) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) pop_nxt = 1'b1;
         end
      end
      rsp_pop <= pop_nxt;
   end

   function automatic logic signed [PIXEL_WIDTH-1:0] rand_pixel();
      logic signed [PIXEL_WIDTH-1:0] v;
      v = PIXEL_WIDTH'($urandom);
      case ($urandom_range(0, 3))
         0: v = PIXEL_WIDTH'(int'($urandom_range(0, 4)) - 2);
         1: v = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
         default: ;
      endcase
      return v;
   endfunction

   task automatic queue_item(logic action, logic signed [PIXEL_WIDTH-1:0] pixel,
                             int unsigned top, bit settle);
      stream_item_type it;
      it.action = action;
      it.pixel  = pixel;
      it.gap    = draw_gap(top);
      it.settle = settle;
      stream_q.push_back(it);
   endtask

   // One whole frame: raster pixels then drains, with ignored drains and dropped pixels mixed in
   task automatic queue_frame(int unsigned rows, int unsigned cols, int unsigned top,
                              bit settle);
      int unsigned n;
      n = rows * cols;
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) queue_item(ACT_DRAIN, rand_pixel(), top, 1'b0);
         queue_item(ACT_PIXEL, rand_pixel(), top, settle && k == n / 2);
         random_items++;
      end
      for (int unsigned k = 0; k < cols; k++) begin
         if (k > 0 && $urandom_range(0, 9) == 0)
            queue_item(ACT_PIXEL, rand_pixel(), top, 1'b0);
         queue_item(ACT_DRAIN, rand_pixel(), top, 1'b0);
         random_items++;
      end
   endtask

   // Wait until the stream is sent and every flag is back, then let the pipe drain
   task automatic wait_quiet();
      do @(posedge clock);
      while (stream_q.size() != 0 || holding || req_push || peak_flags_q.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_ROWS) rows_reg = value[ROWS_CFG_W-1:0];
      else cols_reg = value[COLS_CFG_W-1:0];
   endtask

   // Stimulus sequence
   initial begin
      int unsigned rows;
      int unsigned cols;
      int unsigned top;
      bit          first_settle;
      logic signed [PIXEL_WIDTH-1:0] grid [9];

      grid = '{PIX_MAX, PIX_MIN, 16'sd0, -16'sd1, 16'sd1, -16'sd1, 16'sd5, 16'sd5, PIX_MAX};
      first_settle = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Zero sizes act as one: a 1x1 frame is always a peak
      write_reg(CSR_FRAME_ROWS, '0);
      write_reg(CSR_FRAME_COLS, '0);
      queue_item(ACT_DRAIN, PIX_MAX, GAP_TOP, 1'b0);
      queue_item(ACT_PIXEL, PIX_MIN, GAP_TOP, 1'b0);
      queue_item(ACT_PIXEL, PIX_MAX, GAP_TOP, 1'b0);
      queue_item(ACT_DRAIN, '0, GAP_TOP, 1'b0);
      queue_item(ACT_DRAIN, '0, GAP_TOP, 1'b0);
      wait_quiet();

      // 3x3 frame with extremes and equal neighbors
      write_reg(CSR_FRAME_ROWS, 16'd3);
      write_reg(CSR_FRAME_COLS, 16'd3);
      queue_item(ACT_DRAIN, '0, GAP_TOP, 1'b0);
      foreach (grid[i]) queue_item(ACT_PIXEL, grid[i], GAP_TOP, 1'b0);
      queue_item(ACT_PIXEL, PIX_MAX, GAP_TOP, 1'b0);
      repeat (3) queue_item(ACT_DRAIN, PIX_MIN, GAP_TOP, 1'b0);
      queue_item(ACT_DRAIN, '0, GAP_TOP, 1'b0);

      // Random frames, a few per setting, some with no idling at all
      while (random_items < RANDOM_ITEMS) begin
         wait_quiet();
         rows = $urandom_range(1, 8);
         cols = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         top = ($urandom_range(0, 3) == 0) ? 0 : GAP_TOP;
         rsp_stall_top = ($urandom_range(0, 3) == 0) ? 0 : GAP_TOP;
         write_reg(CSR_FRAME_ROWS, CSR_DATA_W'(rows));
         write_reg(CSR_FRAME_COLS, CSR_DATA_W'(cols));
         repeat ($urandom_range(1, 3)) begin
            queue_frame(rows, cols, top, first_settle || $urandom_range(0, 5) == 0);
            first_settle = 1'b0;
         end
      end

      // Tallest frame with an oversized column count, left open: the count clamps to the
      // full line store width, so the second row starts after MAX_COLS pixels
      wait_quiet();
      rsp_stall_top = GAP_TOP;
      write_reg(CSR_FRAME_ROWS, 16'hFFFF);
      write_reg(CSR_FRAME_COLS, 16'hFFFF);
      for (int unsigned k = 0; k < MAX_COLS + OPEN_EXTRA; k++) begin
         if ($urandom_range(0, 9) == 0) queue_item(ACT_DRAIN, rand_pixel(), GAP_TOP, 1'b0);
         queue_item(ACT_PIXEL, rand_pixel(), GAP_TOP, 1'b0);
      end
      wait_quiet();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/lpm4n_pkg.sv
hw/rtl/lpm4n_front.sv
hw/rtl/lpm4n_cmd_queue.sv
hw/rtl/lpm4n_back.sv
hw/rtl/local_peak_marker_4n.sv
verif/tb_top.sv
